/* src/pcc_pkg.sv */
// ============================================================================
// pcc_pkg
// Shared constants, tables, types and helpers of the polar/Cartesian converter.
// ============================================================================
`default_nettype none

package pcc_pkg;

   // Build-time choices
   localparam int ITERATIONS  = 16;
   localparam int COORD_WIDTH = 16;

   // Guard bits below the Q8.8 point and the number of CORDIC stages
   localparam int GUARD = (COORD_WIDTH - 8 < 0) ? 0 :
                          ((COORD_WIDTH - 8 > 24) ? 24 : COORD_WIDTH - 8);
   localparam int ITER  = (ITERATIONS > 24) ? 24 : ((ITERATIONS < 1) ? 1 : ITERATIONS);

   // Datapath width: 16 magnitude bits, guard bits, sign and CORDIC growth
   localparam int DW         = 19 + GUARD;
   localparam int LO_W       = DW / 2;
   localparam int HI_W       = DW - LO_W;
   localparam int GAIN_SHIFT = 30 + GUARD;
   localparam int PROD_W     = DW + 31;
   localparam int RAD_W      = PROD_W - GAIN_SHIFT;

   // Inverse CORDIC gain in Q0.30
   localparam logic [29:0] INV_GAIN = 30'h26DD3B6A;

   // Angle scaling: the full circle is 46080 units of 1/128 degree
   localparam int DEG_CIRCLE = 46080;
   localparam int DEG_DIV    = DEG_CIRCLE / 1024;
   localparam int BAM_BIAS   = (DEG_CIRCLE / 2) / 1024;
   localparam int RECIP_SHIFT = 21;
   localparam logic [15:0] DEG_RECIP = 16'((1 << RECIP_SHIFT) / DEG_DIV + 1);

   localparam logic signed [31:0] Z_LIMIT     = 32'sh4000_0000;
   localparam logic [31:0]        Z_HALF      = 32'h8000_0000;
   localparam logic [15:0]        ANG_HALF    = 16'd23040;
   localparam logic [15:0]        ANG_QUARTER = 16'd11520;

   // Arctangent of 2^-i as a binary angle
   localparam logic [31:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // Binary angle of each remainder left after division by DEG_DIV
   typedef logic [21:0] pcc_bamtab_type [64];

   function automatic pcc_bamtab_type build_bam_tab();
      pcc_bamtab_type    t;
      longint unsigned   v;
      for (int i = 0; i < 64; i++) begin
         if (i < DEG_DIV) begin
            v = ((longint'(i) << 22) + longint'(BAM_BIAS)) / DEG_DIV;
         end else begin
            v = 0;
         end
         t[i] = 22'(v);
      end
      return t;
   endfunction

   localparam pcc_bamtab_type BAM_TAB = build_bam_tab();

   // Item fields carried down the pipe
   typedef struct packed {
      logic        kind;
      logic [15:0] x_in;
      logic [15:0] y_in;
      logic [15:0] radius_in;
      logic [15:0] angle_in;
      logic        origin;
      logic        y_zero;
      logic        x_zero;
   } pcc_item_type;

   // CORDIC state
   typedef struct packed {
      logic signed [DW-1:0] x;
      logic signed [DW-1:0] y;
      logic [31:0]          z;
   } pcc_rot_type;

   // One micro-rotation; vec selects vectoring mode
   function automatic pcc_rot_type cordic_step(pcc_rot_type s, logic vec, logic [4:0] idx);
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic                 ccw;
      pcc_rot_type          r;
      dx  = s.y >>> idx;
      dy  = s.x >>> idx;
      ccw = vec ? s.y[DW-1] : ~s.z[31];
      if (ccw) begin
         r.x = s.x - dx;
         r.y = s.y + dy;
         r.z = s.z - ATAN_TAB[idx];
      end else begin
         r.x = s.x + dx;
         r.y = s.y - dy;
         r.z = s.z + ATAN_TAB[idx];
      end
      return r;
   endfunction

   // Clip a rounded magnitude into Q8.8 with its sign; returns {clipped, value}
   function automatic logic [16:0] to_q88(logic neg, logic [RAD_W-1:0] r);
      logic [RAD_W-1:0] m;
      logic             s;
      logic [15:0]      v;
      if (neg) begin
         s = r > RAD_W'(32768);
         m = s ? RAD_W'(32768) : r;
         v = 16'(m);
         v = ~v + 16'd1;
      end else begin
         s = r > RAD_W'(32767);
         m = s ? RAD_W'(32767) : r;
         v = 16'(m);
      end
      return {s, v};
   endfunction

endpackage

`default_nettype wire

/* src/polar_cartesian_converter.sv */
// ============================================================================
// polar_cartesian_converter
// Pipelined CORDIC converting polar to Cartesian and Cartesian to polar.
// ============================================================================
// Takes one transaction per clock cycle; busy is always low. Each result
// passes through four stages of angle scaling and set-up, one stage per
// CORDIC micro-rotation and three stages of gain removal, rounding and
// output. strobe marks a result for exactly one cycle; the receiver must
// take it then, as there is no hold-off.
`default_nettype none

module polar_cartesian_converter (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire                req_kind,
   input  wire  signed [15:0] req_x_in,
   input  wire  signed [15:0] req_y_in,
   input  wire         [15:0] req_radius_in,
   input  wire  signed [15:0] req_angle_in,
   output logic               strobe,
   output logic signed [15:0] rsp_x_out,
   output logic signed [15:0] rsp_y_out,
   output logic        [15:0] rsp_radius_out,
   output logic signed [15:0] rsp_angle_out,
   output logic               rsp_saturated
);

   localparam int ITER = pcc_pkg::ITER;
   localparam int DW   = pcc_pkg::DW;
   localparam int LO_W = pcc_pkg::LO_W;
   localparam int HI_W = pcc_pkg::HI_W;
   localparam int PROD_W = pcc_pkg::PROD_W;
   localparam int RAD_W  = pcc_pkg::RAD_W;
   localparam int GS     = pcc_pkg::GAIN_SHIFT;
   localparam int LAT    = ITER + 7;
   localparam logic [PROD_W-1:0] ROUND_BIT = PROD_W'(1) << (GS - 1);

   // Never stall the caller
   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   logic                  s1_valid_ff;
   pcc_pkg::pcc_item_type s1_item_ff, s1_item_in;
   logic [15:0]           s1_mag_ff, s1_mag_in;
   logic                  s1_neg_ff;
   logic [31:0]           s1_prod_ff, s1_prod_in;

   // Take the angle magnitude and start the division by 45
   always_comb begin
      s1_item_in.kind      = req_kind;
      s1_item_in.x_in      = req_x_in;
      s1_item_in.y_in      = req_y_in;
      s1_item_in.radius_in = req_radius_in;
      s1_item_in.angle_in  = req_angle_in;
      s1_item_in.origin    = (req_x_in == 16'sd0) && (req_y_in == 16'sd0);
      s1_item_in.y_zero    = (req_y_in == 16'sd0);
      s1_item_in.x_zero    = (req_x_in == 16'sd0);
      s1_mag_in  = req_angle_in[15] ? 16'(~req_angle_in + 16'sd1) : req_angle_in;
      s1_prod_in = 32'(s1_mag_in) * 32'(pcc_pkg::DEG_RECIP);
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_mag_ff  <= s1_mag_in;
      s1_neg_ff  <= req_angle_in[15];
      s1_prod_ff <= s1_prod_in;
   end

   // ---------------------------------------------------------------- stage 2
   logic                  s2_valid_ff;
   pcc_pkg::pcc_item_type s2_item_ff;
   logic [9:0]            s2_quo_ff, s2_quo_in;
   logic [5:0]            s2_rem_ff, s2_rem_in;
   logic                  s2_neg_ff;

   // Finish quotient and remainder of the magnitude by 45
   always_comb begin
      s2_quo_in = s1_prod_ff[pcc_pkg::RECIP_SHIFT +: 10];
      s2_rem_in = 6'(s1_mag_ff - 16'(16'(s2_quo_in) * 16'(pcc_pkg::DEG_DIV)));
   end

   always_ff @(posedge clock) begin
      s2_item_ff <= s1_item_ff;
      s2_quo_ff  <= s2_quo_in;
      s2_rem_ff  <= s2_rem_in;
      s2_neg_ff  <= s1_neg_ff;
   end

   // ---------------------------------------------------------------- stage 3
   logic                  s3_valid_ff;
   pcc_pkg::pcc_item_type s3_item_ff;
   logic [31:0]           s3_z_ff, s3_z_in, s3_q;

   // Assemble the binary angle and apply its sign
   always_comb begin
      s3_q    = {s2_quo_ff, 22'd0} + 32'(pcc_pkg::BAM_TAB[s2_rem_ff]);
      s3_z_in = s2_neg_ff ? (~s3_q + 32'd1) : s3_q;
   end

   always_ff @(posedge clock) begin
      s3_item_ff <= s2_item_ff;
      s3_z_ff    <= s3_z_in;
   end

   // ------------------------------------------------- set-up of the rotation
   pcc_pkg::pcc_rot_type  cord_ff   [ITER+1];
   pcc_pkg::pcc_item_type citem_ff  [ITER+1];
   logic                  cvalid_ff [ITER+1];
   pcc_pkg::pcc_rot_type  cord0_in;

   logic signed [31:0]    init_zs;
   logic                  init_fold;
   logic [15:0]           init_ax, init_ay;
   logic signed [DW-1:0]  init_r, init_xv, init_yv;

   // Fold the angle into the right half plane, or reflect x for vectoring
   always_comb begin
      init_zs   = s3_z_ff;
      init_fold = (init_zs > pcc_pkg::Z_LIMIT) || (init_zs < -pcc_pkg::Z_LIMIT);
      init_ax   = s3_item_ff.x_in[15] ? (~s3_item_ff.x_in + 16'd1) : s3_item_ff.x_in;
      init_ay   = s3_item_ff.y_in[15] ? (~s3_item_ff.y_in + 16'd1) : s3_item_ff.y_in;
      init_r    = DW'(s3_item_ff.radius_in) << pcc_pkg::GUARD;
      init_xv   = DW'(init_ax) << pcc_pkg::GUARD;
      init_yv   = DW'(init_ay) << pcc_pkg::GUARD;
      if (!s3_item_ff.kind) begin
         cord0_in.x = init_fold ? -init_r : init_r;
         cord0_in.y = '0;
         cord0_in.z = init_fold ? (s3_z_ff + pcc_pkg::Z_HALF) : s3_z_ff;
      end else begin
         cord0_in.x = init_xv;
         cord0_in.y = (s3_item_ff.x_in[15] ^ s3_item_ff.y_in[15]) ? -init_yv : init_yv;
         cord0_in.z = s3_item_ff.x_in[15] ? pcc_pkg::Z_HALF : 32'd0;
      end
   end

   // Advance the micro-rotation stages
   always_ff @(posedge clock) begin
      cord_ff[0]  <= cord0_in;
      citem_ff[0] <= s3_item_ff;
      for (int k = 0; k < ITER; k++) begin
         cord_ff[k+1]  <= pcc_pkg::cordic_step(cord_ff[k], citem_ff[k].kind, 5'(k));
         citem_ff[k+1] <= citem_ff[k];
      end
   end

   // ------------------------------------------------- gain stage 1: low part
   logic                  g1_valid_ff;
   pcc_pkg::pcc_item_type g1_item_ff;
   logic [LO_W+29:0]      g1_plox_ff, g1_ploy_ff;
   logic [HI_W-1:0]       g1_hix_ff, g1_hiy_ff;
   logic                  g1_sx_ff, g1_sy_ff;
   logic [47:0]           g1_dprod_ff;
   logic                  g1_dneg_ff;
   logic [DW-1:0]         g1_magx, g1_magy;
   logic [31:0]           g1_zm;
   logic                  g1_dneg;

   // Split magnitudes for the gain product; scale the angle to degrees
   always_comb begin
      g1_magx = cord_ff[ITER].x[DW-1] ? DW'(-cord_ff[ITER].x) : DW'(cord_ff[ITER].x);
      g1_magy = cord_ff[ITER].y[DW-1] ? DW'(-cord_ff[ITER].y) : DW'(cord_ff[ITER].y);
      g1_dneg = cord_ff[ITER].z > pcc_pkg::Z_HALF;
      g1_zm   = g1_dneg ? (~cord_ff[ITER].z + 32'd1) : cord_ff[ITER].z;
   end

   always_ff @(posedge clock) begin
      g1_item_ff  <= citem_ff[ITER];
      g1_plox_ff  <= (LO_W+30)'(g1_magx[LO_W-1:0]) * (LO_W+30)'(pcc_pkg::INV_GAIN);
      g1_ploy_ff  <= (LO_W+30)'(g1_magy[LO_W-1:0]) * (LO_W+30)'(pcc_pkg::INV_GAIN);
      g1_hix_ff   <= g1_magx[DW-1:LO_W];
      g1_hiy_ff   <= g1_magy[DW-1:LO_W];
      g1_sx_ff    <= cord_ff[ITER].x[DW-1];
      g1_sy_ff    <= cord_ff[ITER].y[DW-1];
      g1_dprod_ff <= 48'(g1_zm) * 48'(pcc_pkg::DEG_CIRCLE);
      g1_dneg_ff  <= g1_dneg;
   end

   // ------------------------------------------ gain stage 2: high part, round
   logic                  g2_valid_ff;
   pcc_pkg::pcc_item_type g2_item_ff;
   logic [RAD_W-1:0]      g2_rx_ff, g2_ry_ff;
   logic                  g2_sx_ff, g2_sy_ff;
   logic [15:0]           g2_ang_ff;
   logic [PROD_W-1:0]     g2_totx, g2_toty;
   logic [47:0]           g2_dsum;
   logic [15:0]           g2_q;

   always_comb begin
      g2_totx = ((PROD_W'(g1_hix_ff) * PROD_W'(pcc_pkg::INV_GAIN)) << LO_W)
                + PROD_W'(g1_plox_ff) + ROUND_BIT;
      g2_toty = ((PROD_W'(g1_hiy_ff) * PROD_W'(pcc_pkg::INV_GAIN)) << LO_W)
                + PROD_W'(g1_ploy_ff) + ROUND_BIT;
      g2_dsum = g1_dprod_ff + 48'h0000_8000_0000;
      g2_q    = g2_dsum[47:32];
   end

   always_ff @(posedge clock) begin
      g2_item_ff <= g1_item_ff;
      g2_rx_ff   <= g2_totx[PROD_W-1:GS];
      g2_ry_ff   <= g2_toty[PROD_W-1:GS];
      g2_sx_ff   <= g1_sx_ff;
      g2_sy_ff   <= g1_sy_ff;
      g2_ang_ff  <= g1_dneg_ff ? (~g2_q + 16'd1) : g2_q;
   end

   // ----------------------------------------------- output: clip and select
   logic               out_valid_ff;
   logic [15:0]        out_x_ff, out_y_ff, out_r_ff, out_a_ff;
   logic               out_sat_ff;
   logic [15:0]        out_x_in, out_y_in, out_r_in, out_a_in;
   logic               out_sat_in;
   logic [16:0]        qx, qy;
   logic [15:0]        abs_x, abs_y;

   always_comb begin
      qx    = pcc_pkg::to_q88(g2_sx_ff, g2_rx_ff);
      qy    = pcc_pkg::to_q88(g2_sy_ff, g2_ry_ff);
      abs_x = g2_item_ff.x_in[15] ? (~g2_item_ff.x_in + 16'd1) : g2_item_ff.x_in;
      abs_y = g2_item_ff.y_in[15] ? (~g2_item_ff.y_in + 16'd1) : g2_item_ff.y_in;
      if (!g2_item_ff.kind) begin
         out_x_in   = qx[15:0];
         out_y_in   = qy[15:0];
         out_r_in   = g2_item_ff.radius_in;
         out_a_in   = g2_item_ff.angle_in;
         out_sat_in = qx[16] | qy[16];
      end else begin
         out_x_in   = g2_item_ff.x_in;
         out_y_in   = g2_item_ff.y_in;
         out_sat_in = 1'b0;
         if (g2_item_ff.origin) begin
            out_r_in = 16'd0;
            out_a_in = 16'd0;
         end else if (g2_item_ff.y_zero) begin
            out_r_in = abs_x;
            out_a_in = g2_item_ff.x_in[15] ? pcc_pkg::ANG_HALF : 16'd0;
         end else if (g2_item_ff.x_zero) begin
            out_r_in = abs_y;
            out_a_in = g2_item_ff.y_in[15] ? (~pcc_pkg::ANG_QUARTER + 16'd1)
                                           : pcc_pkg::ANG_QUARTER;
         end else begin
            out_r_in = (g2_rx_ff > RAD_W'(16'hFFFF)) ? 16'hFFFF : g2_rx_ff[15:0];
            out_a_in = g2_ang_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_r_ff   <= out_r_in;
      out_a_ff   <= out_a_in;
      out_sat_ff <= out_sat_in;
   end

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         g1_valid_ff  <= 1'b0;
         g2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= ITER; k++) begin
            cvalid_ff[k] <= 1'b0;
         end
      end else begin
         s1_valid_ff  <= start & ~busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         cvalid_ff[0] <= s3_valid_ff;
         for (int k = 0; k < ITER; k++) begin
            cvalid_ff[k+1] <= cvalid_ff[k];
         end
         g1_valid_ff  <= cvalid_ff[ITER];
         g2_valid_ff  <= g1_valid_ff;
         out_valid_ff <= g2_valid_ff;
      end
   end

   assign strobe         = out_valid_ff;
   assign rsp_x_out      = out_x_ff;
   assign rsp_y_out      = out_y_ff;
   assign rsp_radius_out = out_r_ff;
   assign rsp_angle_out  = out_a_ff;
   assign rsp_saturated  = out_sat_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(start, LAT))
      else $error("result without a transaction at the pipeline depth");

   a_polar_no_sat: assert property (@(posedge clock) disable iff (reset)
      (strobe && $past(req_kind, LAT)) |-> !rsp_saturated)
      else $error("saturation flagged on a Cartesian to polar result");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (strobe && $past(req_kind, LAT)) |->
      (rsp_angle_out <= 16'sd23040 && rsp_angle_out >= -16'sd23040))
      else $error("computed angle outside half a turn");
`endif

endmodule

`default_nettype wire
